// ===== hw/rtl/hoc_pkg.sv =====
// ----------------------------------------------------------------------------
// hoc_pkg: shared types and constants of the horizon occlusion culler
// Operation codes, register indexes, sequencer states and the token that
// walks the row of horizon cells.
// ----------------------------------------------------------------------------
package hoc_pkg;

  // Bin index width: holds -1 .. 4096 signed
  localparam int IDX_W = 14;
  localparam int H_W   = 32;

  // Divider operand widths
  localparam int DIV_N_W = 65;
  localparam int DIV_D_W = 49;
  localparam int DIV_Q_W = 31;

  localparam logic signed [15:0]    COEF_033 = 16'sd21627;
  localparam logic signed [H_W-1:0] H_MIN    = {1'b1, {(H_W-1){1'b0}}};

  typedef enum logic [1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_ADD   = 2'd1,
    FUNC_QUERY = 2'd2,
    FUNC_NOP   = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    CFG_CULL_EN = 3'd0,
    CFG_CAM_X   = 3'd1,
    CFG_CAM_Y   = 3'd2,
    CFG_CAM_Z   = 3'd3,
    CFG_DIR_X   = 3'd4,
    CFG_DIR_Y   = 3'd5,
    CFG_CEIL_Z  = 3'd6,
    CFG_NONE    = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    TOK_TEST  = 2'd0,
    TOK_RAISE = 2'd1,
    TOK_CLEAR = 2'd2,
    TOK_IDLE  = 2'd3
  } tok_op_e;

  typedef enum logic [3:0] {
    S_IDLE, S_DIFF, S_MUL, S_SUM, S_CHK, S_DSTART, S_DWAIT,
    S_XMUL, S_XACC, S_BMUL, S_BRANGE, S_TWAIT, S_RWAIT, S_DONE
  } state_e;

  typedef struct packed {
    logic                    valid;
    tok_op_e                 op;
    logic signed [IDX_W-1:0] lo;
    logic signed [IDX_W-1:0] hi;
    logic signed [H_W-1:0]   hval;
    logic                    occ;
  } tok_t;

endpackage

// ===== hw/rtl/horizon_occlusion_culler.sv =====
// ----------------------------------------------------------------------------
// horizon_occlusion_culler: horizon-line occlusion test for terrain boxes
// Sequencer, shared divider and a row of HORIZON_BINS horizon cells.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid_i/in_ready_o) carries one operation per transfer:
//    clear the horizon, add an occluder box, query a box or do nothing.
//    Every transfer gives exactly one result transfer (occluded_o, tested_o).
//  - Configuration channel (cfg_*) writes camera, view direction, ceiling and
//    enable; it is always ready. Write it only while the block is idle.
//  - One item at a time. Each corner in front of the camera takes three
//    bit-serial divisions (24 or 31 quotient bits) in the shared divider; then
//    the test token walks the cell row, and walks it once more when an add
//    raises the line. A clear sends one token along the row; an untested box
//    skips the divisions or stops at the first corner at or behind the camera.
//  - Reset sets the configuration and control registers to their defaults
//    and every bin to the most negative height at once; no sweep is needed.
//  - When the receiver stalls, the result holds in the output register and
//    the next input transfer is taken; its result waits until the slot frees.
// ----------------------------------------------------------------------------
module horizon_occlusion_culler #(
  parameter int HORIZON_BINS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic signed [31:0] box_xmin_i,
  input  logic signed [31:0] box_xmax_i,
  input  logic signed [31:0] box_ymin_i,
  input  logic signed [31:0] box_ymax_i,
  input  logic signed [31:0] box_zmin_i,
  input  logic signed [31:0] box_zmax_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        occluded_o,
  output logic        tested_o
);

  localparam int IW = hoc_pkg::IDX_W;
  localparam int NW = hoc_pkg::DIV_N_W;
  localparam int DW = hoc_pkg::DIV_D_W;
  localparam logic signed [13:0] BINS_S = 14'(HORIZON_BINS);
  localparam logic signed [40:0] BINS_W = 41'(HORIZON_BINS);

  // Configuration registers
  logic               cull_en_q;
  logic signed [31:0] cam_x_q, cam_y_q, cam_z_q, ceil_z_q;
  logic signed [15:0] dir_x_q, dir_y_q;
  logic               active;

  assign cfg_ready_o = 1'b1;
  assign active      = cull_en_q && (cam_z_q <= ceil_z_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cull_en_q <= 1'b1;
      cam_x_q   <= '0;
      cam_y_q   <= '0;
      cam_z_q   <= '0;
      dir_x_q   <= '0;
      dir_y_q   <= 16'sd16384;
      ceil_z_q  <= 32'sh7FFFFFFF;
    end else if (cfg_valid_i) begin
      unique case (hoc_pkg::cfg_idx_e'(cfg_index_i))
        hoc_pkg::CFG_CULL_EN: cull_en_q <= cfg_data_i[0];
        hoc_pkg::CFG_CAM_X:   cam_x_q   <= cfg_data_i;
        hoc_pkg::CFG_CAM_Y:   cam_y_q   <= cfg_data_i;
        hoc_pkg::CFG_CAM_Z:   cam_z_q   <= cfg_data_i;
        hoc_pkg::CFG_DIR_X:   dir_x_q   <= cfg_data_i[15:0];
        hoc_pkg::CFG_DIR_Y:   dir_y_q   <= cfg_data_i[15:0];
        hoc_pkg::CFG_CEIL_Z:  ceil_z_q  <= cfg_data_i;
        default:              cull_en_q <= cull_en_q;
      endcase
    end
  end

  // Sequencer state and datapath registers
  hoc_pkg::state_e    state_q, state_d;
  logic [1:0]         corner_q, corner_d;
  logic [1:0]         dsel_q, dsel_d;
  hoc_pkg::func_e     func_q, func_d;
  logic signed [31:0] bx0_q, bx0_d, bx1_q, bx1_d, by0_q, by0_d, by1_q, by1_d;
  logic signed [32:0] dzlo_q, dzlo_d, dzhi_q, dzhi_d;
  logic signed [32:0] dx_q, dx_d, dy_q, dy_d;
  logic signed [48:0] pa_q, pa_d, pb_q, pb_d, pc_q, pc_d, pd_q, pd_d;
  logic signed [49:0] ry_q, ry_d, rx_q, rx_d;
  logic signed [24:0] p_q, p_d;
  logic signed [31:0] ht_q, ht_d, hb_q, hb_d;
  logic signed [40:0] pm_q, pm_d;
  logic signed [25:0] xsmin_q, xsmin_d, xsmax_q, xsmax_d;
  logic signed [31:0] hhi_q, hhi_d, hlo_q, hlo_d;
  logic signed [39:0] pbmin_q, pbmin_d, pbmax_q, pbmax_d;
  logic signed [IW-1:0] rlo_q, rlo_d, rhi_q, rhi_d;
  logic               res_occ_q, res_occ_d, res_tst_q, res_tst_d;
  logic               out_valid_q, out_valid_d, occ_out_q, occ_out_d;
  logic               tst_out_q, tst_out_d;
  hoc_pkg::tok_t      tok_in_q, tok_in_d;
  hoc_pkg::tok_t      tok_chain [HORIZON_BINS+1];

  // Divider hookup
  logic                         div_start, div_done;
  logic [NW-1:0]                div_num;
  logic [4:0]                   div_qbits;
  logic [hoc_pkg::DIV_Q_W-1:0]  div_quot;

  hoc_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (DW'(ry_q)),
    .qbits_i (div_qbits),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Operand select for the three divisions of a corner
  logic [49:0] rx_mag;
  logic [32:0] dzhi_mag, dzlo_mag;
  assign rx_mag   = rx_q[49] ? 50'(-rx_q) : 50'(rx_q);
  assign dzhi_mag = dzhi_q[32] ? 33'(-dzhi_q) : 33'(dzhi_q);
  assign dzlo_mag = dzlo_q[32] ? 33'(-dzlo_q) : 33'(dzlo_q);

  always_comb begin
    unique case (dsel_q)
      2'd0:    begin div_num = NW'({rx_mag, 16'd0});   div_qbits = 5'd24; end
      2'd1:    begin div_num = NW'({dzhi_mag, 30'd0}); div_qbits = 5'd31; end
      default: begin div_num = NW'({dzlo_mag, 30'd0}); div_qbits = 5'd31; end
    endcase
  end

  // Bin range helpers: clamp lower bound into [0, B], upper into [-1, B-1]
  function automatic logic signed [IW-1:0] clamp_lo(input logic signed [40:0] v);
    if (v < 41'sd0)        return '0;
    else if (v > BINS_W)   return IW'(HORIZON_BINS);
    else                   return IW'(v);
  endfunction

  function automatic logic signed [IW-1:0] clamp_hi(input logic signed [40:0] v);
    if (v < -41'sd1)                 return '1;
    else if (v > BINS_W - 41'sd1)    return IW'(HORIZON_BINS - 1);
    else                             return IW'(v);
  endfunction

  logic signed [40:0] fl_min, fl_max, cl_min, cl_max;
  logic signed [IW-1:0] tlo, thi;
  assign fl_min = 41'(pbmin_q >>> 16);
  assign fl_max = 41'(pbmax_q >>> 16);
  assign cl_min = 41'((41'(pbmin_q) + 41'sd65535) >>> 16);
  assign cl_max = 41'((41'(pbmax_q) + 41'sd65535) >>> 16);
  assign tlo    = clamp_lo(fl_min);
  assign thi    = clamp_hi(cl_max);

  logic               out_free;
  logic signed [24:0] pmag;
  logic signed [31:0] hmag;
  logic signed [25:0] xs;
  hoc_pkg::tok_t      tok_end;

  assign out_free = !out_valid_q || out_ready_i;
  assign pmag     = $signed({1'b0, div_quot[23:0]});
  assign hmag     = $signed({1'b0, div_quot[30:0]});
  assign xs       = 26'(pm_q >>> 16) + 26'sd32768;
  assign tok_end  = tok_chain[HORIZON_BINS];

  always_comb begin
    state_d = state_q;   corner_d = corner_q; dsel_d = dsel_q;   func_d = func_q;
    bx0_d = bx0_q; bx1_d = bx1_q; by0_d = by0_q; by1_d = by1_q;
    dzlo_d = dzlo_q; dzhi_d = dzhi_q; dx_d = dx_q; dy_d = dy_q;
    pa_d = pa_q; pb_d = pb_q; pc_d = pc_q; pd_d = pd_q;
    ry_d = ry_q; rx_d = rx_q; p_d = p_q; ht_d = ht_q; hb_d = hb_q; pm_d = pm_q;
    xsmin_d = xsmin_q; xsmax_d = xsmax_q; hhi_d = hhi_q; hlo_d = hlo_q;
    pbmin_d = pbmin_q; pbmax_d = pbmax_q; rlo_d = rlo_q; rhi_d = rhi_q;
    res_occ_d = res_occ_q; res_tst_d = res_tst_q;
    occ_out_d = occ_out_q; tst_out_d = tst_out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    tok_in_d = '0;
    tok_in_d.op = hoc_pkg::TOK_IDLE;
    div_start = 1'b0;
    in_ready_o = (state_q == hoc_pkg::S_IDLE);

    unique case (state_q)
      hoc_pkg::S_IDLE: begin
        if (in_valid_i) begin
          func_d = hoc_pkg::func_e'(func_i);
          bx0_d = box_xmin_i; bx1_d = box_xmax_i;
          by0_d = box_ymin_i; by1_d = box_ymax_i;
          dzlo_d = 33'(box_zmin_i) - 33'(cam_z_q);
          dzhi_d = 33'(box_zmax_i) - 33'(cam_z_q);
          res_occ_d = 1'b0;
          res_tst_d = 1'b0;
          corner_d  = 2'd0;
          if (hoc_pkg::func_e'(func_i) == hoc_pkg::FUNC_CLEAR) begin
            if (active) begin
              tok_in_d.valid = 1'b1;
              tok_in_d.op    = hoc_pkg::TOK_CLEAR;
              state_d        = hoc_pkg::S_RWAIT;
            end else begin
              state_d = hoc_pkg::S_DONE;
            end
          end else if (hoc_pkg::func_e'(func_i) == hoc_pkg::FUNC_NOP || !active) begin
            state_d = hoc_pkg::S_DONE;
          end else begin
            state_d = hoc_pkg::S_DIFF;
          end
        end
      end
      hoc_pkg::S_DIFF: begin
        dx_d = 33'(corner_q[1] ? bx1_q : bx0_q) - 33'(cam_x_q);
        dy_d = 33'(corner_q[0] ? by1_q : by0_q) - 33'(cam_y_q);
        state_d = hoc_pkg::S_MUL;
      end
      hoc_pkg::S_MUL: begin
        pa_d = dir_x_q * dx_q;
        pb_d = dir_y_q * dy_q;
        pc_d = dir_x_q * dy_q;
        pd_d = dir_y_q * dx_q;
        state_d = hoc_pkg::S_SUM;
      end
      hoc_pkg::S_SUM: begin
        ry_d = 50'(pa_q) + 50'(pb_q);
        rx_d = 50'(pc_q) - 50'(pd_q);
        state_d = hoc_pkg::S_CHK;
      end
      hoc_pkg::S_CHK: begin
        // corner at or behind the camera: untested, no update
        if (ry_q <= 50'sd0) begin
          state_d = hoc_pkg::S_DONE;
        end else begin
          dsel_d  = 2'd0;
          state_d = hoc_pkg::S_DSTART;
        end
      end
      hoc_pkg::S_DSTART: begin
        div_start = 1'b1;
        state_d   = hoc_pkg::S_DWAIT;
      end
      hoc_pkg::S_DWAIT: begin
        if (div_done) begin
          unique case (dsel_q)
            2'd0:    p_d  = rx_q[49] ? -pmag : pmag;
            2'd1:    ht_d = dzhi_q[32] ? -hmag : hmag;
            default: hb_d = dzlo_q[32] ? -hmag : hmag;
          endcase
          if (dsel_q == 2'd2) begin
            state_d = hoc_pkg::S_XMUL;
          end else begin
            dsel_d  = dsel_q + 2'd1;
            state_d = hoc_pkg::S_DSTART;
          end
        end
      end
      hoc_pkg::S_XMUL: begin
        pm_d    = p_q * hoc_pkg::COEF_033;
        state_d = hoc_pkg::S_XACC;
      end
      hoc_pkg::S_XACC: begin
        if (corner_q == 2'd0 || xs < xsmin_q) xsmin_d = xs;
        if (corner_q == 2'd0 || xs > xsmax_q) xsmax_d = xs;
        if (corner_q == 2'd0 || ht_q > hhi_q) hhi_d = ht_q;
        if (corner_q == 2'd0 || hb_q < hlo_q) hlo_d = hb_q;
        if (corner_q == 2'd3) begin
          state_d = hoc_pkg::S_BMUL;
        end else begin
          corner_d = corner_q + 2'd1;
          state_d  = hoc_pkg::S_DIFF;
        end
      end
      hoc_pkg::S_BMUL: begin
        pbmin_d = xsmin_q * BINS_S;
        pbmax_d = xsmax_q * BINS_S;
        state_d = hoc_pkg::S_BRANGE;
      end
      hoc_pkg::S_BRANGE: begin
        rlo_d = clamp_lo(cl_min);
        rhi_d = clamp_hi(fl_max);
        tok_in_d.valid = 1'b1;
        tok_in_d.op    = hoc_pkg::TOK_TEST;
        tok_in_d.lo    = tlo;
        tok_in_d.hi    = thi;
        tok_in_d.hval  = hhi_q;
        tok_in_d.occ   = thi >= tlo;
        state_d        = hoc_pkg::S_TWAIT;
      end
      hoc_pkg::S_TWAIT: begin
        if (tok_end.valid) begin
          res_occ_d = tok_end.occ;
          res_tst_d = 1'b1;
          if (func_q == hoc_pkg::FUNC_ADD && !tok_end.occ) begin
            tok_in_d.valid = 1'b1;
            tok_in_d.op    = hoc_pkg::TOK_RAISE;
            tok_in_d.lo    = rlo_q;
            tok_in_d.hi    = rhi_q;
            tok_in_d.hval  = hlo_q;
            state_d        = hoc_pkg::S_RWAIT;
          end else begin
            state_d = hoc_pkg::S_DONE;
          end
        end
      end
      hoc_pkg::S_RWAIT: begin
        if (tok_end.valid) state_d = hoc_pkg::S_DONE;
      end
      hoc_pkg::S_DONE: begin
        // hold the result until the output slot frees
        if (out_free) begin
          out_valid_d = 1'b1;
          occ_out_d   = res_occ_q;
          tst_out_d   = res_tst_q;
          state_d     = hoc_pkg::S_IDLE;
        end
      end
      default: state_d = hoc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hoc_pkg::S_IDLE;
      corner_q    <= '0;
      dsel_q      <= '0;
      out_valid_q <= 1'b0;
      tok_in_q    <= '0;
    end else begin
      state_q     <= state_d;
      corner_q    <= corner_d;
      dsel_q      <= dsel_d;
      out_valid_q <= out_valid_d;
      tok_in_q    <= tok_in_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q <= func_d;
    bx0_q <= bx0_d; bx1_q <= bx1_d; by0_q <= by0_d; by1_q <= by1_d;
    dzlo_q <= dzlo_d; dzhi_q <= dzhi_d; dx_q <= dx_d; dy_q <= dy_d;
    pa_q <= pa_d; pb_q <= pb_d; pc_q <= pc_d; pd_q <= pd_d;
    ry_q <= ry_d; rx_q <= rx_d; p_q <= p_d; ht_q <= ht_d; hb_q <= hb_d;
    pm_q <= pm_d; xsmin_q <= xsmin_d; xsmax_q <= xsmax_d;
    hhi_q <= hhi_d; hlo_q <= hlo_d; pbmin_q <= pbmin_d; pbmax_q <= pbmax_d;
    rlo_q <= rlo_d; rhi_q <= rhi_d;
    res_occ_q <= res_occ_d; res_tst_q <= res_tst_d;
    occ_out_q <= occ_out_d; tst_out_q <= tst_out_d;
  end

  // Row of horizon cells; the token advances one bin per cycle
  assign tok_chain[0] = tok_in_q;

  for (genvar g = 0; g < HORIZON_BINS; g++) begin : g_cell
    hoc_cell #(.BIN_INDEX(g)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .tok_i  (tok_chain[g]),
      .tok_o  (tok_chain[g+1])
    );
  end

  assign out_valid_o = out_valid_q;
  assign occluded_o  = occ_out_q;
  assign tested_o    = tst_out_q;

endmodule

// ===== hw/rtl/hoc_divider.sv =====
// ----------------------------------------------------------------------------
// hoc_divider: saturating restoring divider
// Returns min(floor(num / den), 2^qbits - 1), one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hoc_divider (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [hoc_pkg::DIV_N_W-1:0]         num_i,
  input  logic [hoc_pkg::DIV_D_W-1:0]         den_i,
  input  logic [4:0]                          qbits_i,
  output logic                                done_o,
  output logic [hoc_pkg::DIV_Q_W-1:0]         quot_o
);

  localparam int NW = hoc_pkg::DIV_N_W;
  localparam int DW = hoc_pkg::DIV_D_W;
  localparam int QW = hoc_pkg::DIV_Q_W;
  localparam int CW = NW + QW;

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [4:0]    cnt_q, cnt_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [NW-1:0] low_q, low_d;
  logic [QW-1:0] quot_q, quot_d;

  logic [CW-1:0] den_sh;
  logic          ovf;
  logic [DW:0]   r2;
  logic          ge;

  assign den_sh = CW'(den_i) << qbits_i;
  assign ovf    = CW'(num_i) >= den_sh;
  assign r2     = {rem_q, low_q[NW-1]};
  assign ge     = r2 >= {1'b0, den_i};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    low_d  = low_q;
    quot_d = quot_q;
    if (start_i) begin
      if (ovf) begin
        quot_d = QW'((32'd1 << qbits_i) - 32'd1);
        done_d = 1'b1;
      end else begin
        rem_d  = DW'(num_i >> qbits_i);
        low_d  = num_i << (7'(NW) - 7'(qbits_i));
        cnt_d  = qbits_i;
        quot_d = '0;
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      rem_d  = ge ? DW'(r2 - {1'b0, den_i}) : r2[DW-1:0];
      quot_d = {quot_q[QW-2:0], ge};
      low_d  = low_q << 1;
      cnt_d  = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    low_q  <= low_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== hw/rtl/hoc_cell.sv =====
// ----------------------------------------------------------------------------
// hoc_cell: one horizon bin
// Holds one height, applies the passing token to it and hands the token on.
// ----------------------------------------------------------------------------
module hoc_cell #(
  parameter int BIN_INDEX = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  hoc_pkg::tok_t tok_i,
  output hoc_pkg::tok_t tok_o
);

  localparam logic signed [hoc_pkg::IDX_W-1:0] MY_IDX = hoc_pkg::IDX_W'(BIN_INDEX);

  logic signed [hoc_pkg::H_W-1:0] bin_q, bin_d;
  hoc_pkg::tok_t                  tok_q, tok_d;
  logic                           in_rng, above;

  assign in_rng = (MY_IDX >= tok_i.lo) && (MY_IDX <= tok_i.hi);
  assign above  = tok_i.hval > bin_q;

  always_comb begin
    bin_d = bin_q;
    tok_d = tok_i;
    if (tok_i.valid) begin
      unique case (tok_i.op)
        hoc_pkg::TOK_TEST:  tok_d.occ = tok_i.occ && !(in_rng && above);
        hoc_pkg::TOK_RAISE: if (in_rng && above) bin_d = tok_i.hval;
        hoc_pkg::TOK_CLEAR: bin_d = hoc_pkg::H_MIN;
        default:            tok_d = tok_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_q <= hoc_pkg::H_MIN;
      tok_q <= '0;
    end else begin
      bin_q <= bin_d;
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule
